// ===== rtl/mpfd_pkg.sv =====
// Shared constants, types and helpers of the page framebuffer drawing engine.
`timescale 1ns / 1ps

package mpfd_pkg;

  localparam int unsigned SCREEN_WIDTH = 128;
  localparam int unsigned SCREEN_HEIGHT = 64;
  localparam int unsigned PAGE_ROWS = 8;
  localparam int unsigned PAGE_COUNT = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int unsigned STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
  localparam int unsigned ADDR_W = $clog2(STORE_BYTES);
  localparam int unsigned GRP_W = 5;
  localparam int unsigned SPAN_COUNT = 4;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam logic [2:0] ROW_FLIP = 3'b111;

  typedef enum logic [2:0] {
    CMD_CLEAR   = 3'd0,
    CMD_PIXEL   = 3'd1,
    CMD_OUTLINE = 3'd2,
    CMD_FILL    = 3'd3,
    CMD_READ    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_READ_WAIT,
    ST_SPAN_LOAD,
    ST_SPAN_STEP,
    ST_MODIFY
  } st_e;

  typedef struct packed {
    logic       en;
    logic [7:0] xs;
    logic [7:0] xl;
    logic [7:0] js;
    logic [7:0] jl;
  } span_t;

  typedef struct packed {
    op_e                        op;
    logic                       color;
    logic [9:0]                 addr;
    span_t [SPAN_COUNT-1:0]     span;
  } desc_t;

  function automatic logic [ADDR_W-1:0] byte_addr(logic [GRP_W-1:0] grp, logic [7:0] col);
    logic [12:0] full;
    full = 13'(grp) * 13'(SCREEN_WIDTH) + 13'(col);
    return full[ADDR_W-1:0];
  endfunction

endpackage

// ===== rtl/mpfd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mpfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mpfd_front.sv =====
// Front end: accepts command beats and turns them into span descriptors.
`timescale 1ns / 1ps

module mpfd_front (
  input  logic               in_valid_i,
  input  logic [2:0]         cmd_i,
  input  logic [7:0]         x_coord_i,
  input  logic [7:0]         y_coord_i,
  input  logic [7:0]         rect_width_i,
  input  logic [7:0]         rect_height_i,
  input  logic               color_i,
  input  logic [9:0]         byte_index_i,
  input  logic               fifo_full_i,
  input  logic               init_busy_i,
  output logic               in_stall_o,
  output logic               push_o,
  output mpfd_pkg::desc_t    desc_o
);

  logic [7:0] x_end, x_last, y_end, y_last, y_next;
  logic       empty, known;

  assign x_end  = x_coord_i + rect_width_i;
  assign x_last = x_coord_i + rect_width_i - 8'd1;
  assign y_end  = y_coord_i + rect_height_i;
  assign y_last = y_coord_i + rect_height_i - 8'd1;
  assign y_next = y_coord_i + 8'd1;
  assign empty  = (rect_width_i == 8'd0) || (rect_height_i == 8'd0);

  assign in_stall_o = fifo_full_i || init_busy_i;
  assign push_o     = in_valid_i && !in_stall_o && known;

  always_comb begin
    desc_o       = '0;
    desc_o.color = color_i;
    desc_o.addr  = byte_index_i;
    desc_o.op    = mpfd_pkg::OP_DRAW;
    known        = 1'b1;
    unique case (cmd_i)
      mpfd_pkg::CMD_CLEAR: begin
        desc_o.op = mpfd_pkg::OP_CLEAR;
      end
      mpfd_pkg::CMD_PIXEL: begin
        desc_o.span[0] = '{en: 1'b1, xs: x_coord_i, xl: x_coord_i,
                           js: y_coord_i, jl: y_coord_i};
      end
      mpfd_pkg::CMD_OUTLINE: begin
        desc_o.span[0] = '{en: !empty && (x_end > x_coord_i), xs: x_coord_i, xl: x_last,
                           js: y_coord_i, jl: y_coord_i};
        desc_o.span[1] = '{en: !empty && (x_end > x_coord_i), xs: x_coord_i, xl: x_last,
                           js: y_last, jl: y_last};
        desc_o.span[2] = '{en: !empty && (y_last > y_next), xs: x_coord_i, xl: x_coord_i,
                           js: y_next, jl: y_last - 8'd1};
        desc_o.span[3] = '{en: !empty && (y_last > y_next), xs: x_last, xl: x_last,
                           js: y_next, jl: y_last - 8'd1};
      end
      mpfd_pkg::CMD_FILL: begin
        desc_o.span[0] = '{en: !empty && (x_end > x_coord_i) && (y_end > y_coord_i),
                           xs: x_coord_i, xl: x_last, js: y_coord_i, jl: y_last};
      end
      mpfd_pkg::CMD_READ: begin
        desc_o.op = mpfd_pkg::OP_READ;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/mpfd_fifo.sv =====
// Short descriptor queue between the front end and the drawing sequencer.
`timescale 1ns / 1ps

module mpfd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mpfd_pkg::desc_t desc_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            head_valid_o,
  output mpfd_pkg::desc_t head_o
);

  localparam int unsigned PTR_W = $clog2(mpfd_pkg::FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(mpfd_pkg::FIFO_DEPTH + 1);

  mpfd_pkg::desc_t  mem_q [mpfd_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o       = cnt_q == CNT_W'(mpfd_pkg::FIFO_DEPTH);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(mpfd_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(mpfd_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

endmodule

// ===== rtl/mpfd_back.sv =====
// Back end: sequencer that clears, reads and draws spans into the frame RAM.
`timescale 1ns / 1ps

module mpfd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  mpfd_pkg::desc_t head_i,
  output logic            pop_o,
  output logic            init_busy_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      read_data_o
);

  localparam int unsigned AW = mpfd_pkg::ADDR_W;
  localparam int unsigned GW = mpfd_pkg::GRP_W;
  localparam int unsigned SW = $clog2(mpfd_pkg::SPAN_COUNT);

  mpfd_pkg::st_e   state_q, state_d;
  logic [SW-1:0]   span_q, span_d;
  logic [7:0]      col_q, col_d;
  logic [GW-1:0]   grp_q, grp_d;
  logic [AW-1:0]   clr_cnt_q, clr_cnt_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_data_q, out_data_d;

  mpfd_pkg::span_t cur;
  logic [7:0]      mask;
  logic [AW-1:0]   addr;
  logic            last_grp, last_col, in_range;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [7:0]      ram_wdata, ram_rdata;

  mpfd_pkg::st_e   adv_state;
  logic [SW-1:0]   adv_span;
  logic [7:0]      adv_col;
  logic [GW-1:0]   adv_grp;
  logic            adv_pop;

  mpfd_ram #(
    .WIDTH(8),
    .DEPTH(mpfd_pkg::STORE_BYTES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign cur      = head_i.span[span_q];
  assign addr     = mpfd_pkg::byte_addr(grp_q, col_q);
  assign last_grp = grp_q == cur.jl[7:3];
  assign last_col = (col_q == cur.xl) ||
                    ((9'(col_q) + 9'd1) >= 9'(mpfd_pkg::SCREEN_WIDTH));
  assign in_range = 14'(head_i.addr) < 14'(mpfd_pkg::STORE_BYTES);

  always_comb begin
    logic [7:0] j;
    logic [7:0] row;
    for (int b = 0; b < 8; b++) begin
      j       = {grp_q, 3'(b) ^ mpfd_pkg::ROW_FLIP};
      row     = {grp_q, 3'(b)};
      mask[b] = (j >= cur.js) && (j <= cur.jl) && (9'(row) < 9'(mpfd_pkg::SCREEN_HEIGHT));
    end
  end

  always_comb begin
    adv_span  = span_q;
    adv_col   = col_q;
    adv_grp   = grp_q;
    adv_pop   = 1'b0;
    adv_state = mpfd_pkg::ST_SPAN_STEP;
    if (!last_grp) begin
      adv_grp = grp_q + 1'b1;
    end else if (!last_col) begin
      adv_col = col_q + 8'd1;
      adv_grp = cur.js[7:3];
    end else if (span_q == SW'(mpfd_pkg::SPAN_COUNT - 1)) begin
      adv_pop   = 1'b1;
      adv_state = mpfd_pkg::ST_IDLE;
    end else begin
      adv_span  = span_q + 1'b1;
      adv_state = mpfd_pkg::ST_SPAN_LOAD;
    end
  end

  always_comb begin
    state_d     = state_q;
    span_d      = span_q;
    col_d       = col_q;
    grp_d       = grp_q;
    clr_cnt_d   = clr_cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = addr;
    ram_raddr   = addr;
    ram_wdata   = (ram_rdata & ~mask) | (head_i.color ? mask : 8'h00);
    unique case (state_q)
      mpfd_pkg::ST_INIT, mpfd_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = 8'h00;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == AW'(mpfd_pkg::STORE_BYTES - 1)) begin
          clr_cnt_d = '0;
          state_d   = mpfd_pkg::ST_IDLE;
          pop_o     = state_q == mpfd_pkg::ST_CLEAR;
        end
      end
      mpfd_pkg::ST_IDLE: begin
        if (head_valid_i) begin
          unique case (head_i.op)
            mpfd_pkg::OP_CLEAR: state_d = mpfd_pkg::ST_CLEAR;
            mpfd_pkg::OP_READ:  state_d = mpfd_pkg::ST_READ;
            mpfd_pkg::OP_DRAW: begin
              span_d  = '0;
              state_d = mpfd_pkg::ST_SPAN_LOAD;
            end
            default: pop_o = 1'b1;
          endcase
        end
      end
      mpfd_pkg::ST_READ: begin
        if (!out_valid_q || !out_stall_i) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(head_i.addr);
          state_d   = mpfd_pkg::ST_READ_WAIT;
        end
      end
      mpfd_pkg::ST_READ_WAIT: begin
        out_valid_d = 1'b1;
        out_data_d  = in_range ? ram_rdata : 8'h00;
        pop_o       = 1'b1;
        state_d     = mpfd_pkg::ST_IDLE;
      end
      mpfd_pkg::ST_SPAN_LOAD: begin
        if (cur.en && (9'(cur.xs) < 9'(mpfd_pkg::SCREEN_WIDTH))) begin
          col_d   = cur.xs;
          grp_d   = cur.js[7:3];
          state_d = mpfd_pkg::ST_SPAN_STEP;
        end else if (span_q == SW'(mpfd_pkg::SPAN_COUNT - 1)) begin
          pop_o   = 1'b1;
          state_d = mpfd_pkg::ST_IDLE;
        end else begin
          span_d = span_q + 1'b1;
        end
      end
      mpfd_pkg::ST_SPAN_STEP: begin
        if (mask != 8'h00) begin
          ram_re  = 1'b1;
          state_d = mpfd_pkg::ST_MODIFY;
        end else begin
          span_d  = adv_span;
          col_d   = adv_col;
          grp_d   = adv_grp;
          pop_o   = adv_pop;
          state_d = adv_state;
        end
      end
      mpfd_pkg::ST_MODIFY: begin
        ram_we  = 1'b1;
        span_d  = adv_span;
        col_d   = adv_col;
        grp_d   = adv_grp;
        pop_o   = adv_pop;
        state_d = adv_state;
      end
      default: state_d = mpfd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mpfd_pkg::ST_INIT;
      span_q      <= '0;
      col_q       <= '0;
      grp_q       <= '0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      span_q      <= span_d;
      col_q       <= col_d;
      grp_q       <= grp_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign init_busy_o = state_q == mpfd_pkg::ST_INIT;
  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;

  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> head_valid_i)
    else $error("Descriptor popped from an empty queue.");

  a_read_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mpfd_pkg::ST_READ_WAIT |-> !out_valid_q)
    else $error("Read data returned while the output register is occupied.");

  a_modify_after_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mpfd_pkg::ST_MODIFY |-> $past(state_q) == mpfd_pkg::ST_SPAN_STEP)
    else $error("Write-back without a preceding byte read.");

  a_clear_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mpfd_pkg::ST_CLEAR && $past(state_q) == mpfd_pkg::ST_CLEAR)
      |-> clr_cnt_q == $past(clr_cnt_q) + 1'b1)
    else $error("Clear sweep skipped or repeated an address.");

endmodule

// ===== rtl/mono_page_framebuffer_draw.sv =====
// Top level of the page framebuffer drawing engine.
//
//   Channel | Direction | Handshake                 | Payload
//   in      | input     | in_valid_i / in_stall_o   | cmd, x_coord, y_coord, rect_width,
//           |           |                           | rect_height, color, byte_index
//   out     | output    | out_valid_o / out_stall_i | read_data (read command only)
//
// After reset the frame RAM is swept to zero, one byte per cycle, and no input beat is
// accepted during that sweep. A clear sweeps every byte back to zero, and a read waits
// while the output register is held by a stall. A rectangle is drawn slot by slot over
// the four span slots, visiting every column and page a span touches, and every write
// is a read-modify-write of the RAM. Unknown commands are dropped on acceptance. The
// queue holds two commands, the one in work too.
`timescale 1ns / 1ps

module mono_page_framebuffer_draw (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] cmd_i,
  input  logic [7:0] x_coord_i,
  input  logic [7:0] y_coord_i,
  input  logic [7:0] rect_width_i,
  input  logic [7:0] rect_height_i,
  input  logic       color_i,
  input  logic [9:0] byte_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o
);

  mpfd_pkg::desc_t push_desc, head_desc;
  logic            push, pop, fifo_full, head_valid, init_busy;

  mpfd_front u_front (
    .in_valid_i   (in_valid_i),
    .cmd_i        (cmd_i),
    .x_coord_i    (x_coord_i),
    .y_coord_i    (y_coord_i),
    .rect_width_i (rect_width_i),
    .rect_height_i(rect_height_i),
    .color_i      (color_i),
    .byte_index_i (byte_index_i),
    .fifo_full_i  (fifo_full),
    .init_busy_i  (init_busy),
    .in_stall_o   (in_stall_o),
    .push_o       (push),
    .desc_o       (push_desc)
  );

  mpfd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .desc_i      (push_desc),
    .pop_i       (pop),
    .full_o      (fifo_full),
    .head_valid_o(head_valid),
    .head_o      (head_desc)
  );

  mpfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head_desc),
    .pop_o       (pop),
    .init_busy_o (init_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_data_o (read_data_o)
  );

endmodule
